// ===== rtl/wban_pkg.sv =====
// wban_pkg: shared types and constants for the wave bin average/normalize block.
// Holds field widths, register indexes, opcodes and the sequencer state type.
// No dependencies.
package wban_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int FRAC_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int COLS_W     = 9;
  localparam int FRAMES_W   = 13;
  localparam int CHANS_W    = 4;

  localparam logic [COLS_W-1:0]   COLS_RESET   = 9'd256;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 13'd4096;
  localparam logic [CHANS_W-1:0]  CHANS_RESET  = 4'd2;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_COLUMNS = 2'd0,
    REG_INPUT_FRAMES   = 2'd1,
    REG_CHANNEL_COUNT  = 2'd2
  } wban_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } wban_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NDIV,
    ST_CLEAR,
    ST_ADVANCE,
    ST_LRD,
    ST_LWR,
    ST_PEAK,
    ST_PEAK_TAIL,
    ST_FRD,
    ST_FCHK,
    ST_FDIV,
    ST_FOUT
  } wban_state_e;

endpackage

// ===== rtl/wave_bin_average_normalize.sv =====
// Load word: accept, RAM read, write back, plus an advance step per column crossed
// on the first channel of a frame. A load start adds the N/M divide and a clear sweep
// over all M*C bins; the end of a load adds a peak sweep over all M*C bins and a tail state.
// Fetch word: RAM read, check, a 15-step restoring divide for sum/peak when needed, output.
// Async active-low reset: config to defaults, counters cleared, peaks at most negative;
// bin RAM contents are not reset and are swept to zero when each load starts.
module wave_bin_average_normalize
  import wban_pkg::*;
#(
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_FRAMES   = 4096,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [LEVEL_W-1:0]   level_o,
  output logic                        zero_peak_o,
  output logic                        last_o
);

  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
  localparam int CHI_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FRAME_W = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(MAX_FRAMES);
  localparam int DEPTH   = MAX_COLUMNS * MAX_CHANNELS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int QUO_W   = (FRAME_W > FRAC_W) ? FRAME_W : FRAC_W;
  localparam int CNT_W   = $clog2(QUO_W + 1);

  localparam logic signed [SUM_W-1:0] PEAK_RESET = {1'b1, {(SUM_W-1){1'b0}}};

  // config
  logic [COLS_W-1:0]   cfg_cols_q;
  logic [FRAMES_W-1:0] cfg_frames_q;
  logic [CHANS_W-1:0]  cfg_chans_q;
  logic [COL_W-1:0]    m_eff;
  logic [FRAME_W-1:0]  n_eff;
  logic [CH_W-1:0]     c_eff;

  wban_state_e state_q, state_d;

  // load run
  logic [FRAME_W-1:0] frame_q, bound_q, nq_q, bound_nxt;
  logic [CH_W-1:0]    ch_q, sw_ch_q, fetch_ch_q;
  logic [COL_W-1:0]   col_q, brem_q, nr_q, brem_nxt, sw_col_q, fetch_col_q;
  logic [COL_W:0]     brem_sum;
  logic               brem_carry;
  logic               load_done_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SUM_W-1:0]    peak_q [MAX_CHANNELS];
  logic                       cmp_valid_q;
  logic [CHI_W-1:0]           cmp_ch_q;

  // fetch result
  logic                       neg_q, res_zp_q;
  logic signed [LEVEL_W-1:0]  res_level_q;
  logic                       out_valid_q, zero_peak_q, last_q;
  logic signed [LEVEL_W-1:0]  level_q;

  logic cfg_acc, in_acc, is_load, load_start, out_free, fout_fire;
  logic ch_last, frame_last, sweep_last, adv_step, fetch_last;

  // RAM and divider hookup
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [SUM_W-1:0]    ram_wdata, ram_rdata;
  logic signed [SUM_W-1:0] sample_ext, sum_s, peak_f;
  logic [SUM_W-1:0]    sum_abs;
  logic                peak_pos, sat;
  logic                div_start, div_done;
  logic [CNT_W-1:0]    div_count;
  logic [SUM_W-1:0]    div_rem_init, div_divisor, div_rem;
  logic [QUO_W-1:0]    div_dividend, div_quo;
  logic [LEVEL_W-1:0]  quo_level;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] col,
                                                input logic [CH_W-1:0]  ch);
    return ADDR_W'(col) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(ch);
  endfunction

  // clamp registers into their working range
  always_comb begin
    if (cfg_cols_q == '0) begin
      m_eff = COL_W'(1);
    end else if (32'(cfg_cols_q) > 32'(MAX_COLUMNS)) begin
      m_eff = COL_W'(MAX_COLUMNS);
    end else begin
      m_eff = COL_W'(cfg_cols_q);
    end
    if (cfg_frames_q == '0) begin
      n_eff = FRAME_W'(1);
    end else if (32'(cfg_frames_q) > 32'(MAX_FRAMES)) begin
      n_eff = FRAME_W'(MAX_FRAMES);
    end else begin
      n_eff = FRAME_W'(cfg_frames_q);
    end
    if (cfg_chans_q == '0) begin
      c_eff = CH_W'(1);
    end else if (32'(cfg_chans_q) > 32'(MAX_CHANNELS)) begin
      c_eff = CH_W'(MAX_CHANNELS);
    end else begin
      c_eff = CH_W'(cfg_chans_q);
    end
  end

  assign cfg_acc    = cfg_valid_i & cfg_ready_o;
  assign in_acc     = in_valid_i & in_ready_o;
  assign is_load    = (wban_op_e'(operation_i) == OP_LOAD);
  assign load_start = (frame_q == '0) && (ch_q == '0);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign fout_fire  = (state_q == ST_FOUT) && out_free;

  assign ch_last    = (ch_q == c_eff - CH_W'(1));
  assign frame_last = (frame_q == n_eff - FRAME_W'(1));
  assign sweep_last = (sw_col_q == m_eff - COL_W'(1)) && (sw_ch_q == c_eff - CH_W'(1));
  assign fetch_last = (fetch_col_q == m_eff - COL_W'(1)) && (fetch_ch_q == c_eff - CH_W'(1));

  // next column boundary: floor((k+1)*N/M) stepped by N div M with remainder carry
  assign adv_step   = (frame_q >= bound_q) && (col_q < m_eff - COL_W'(1));
  assign brem_sum   = {1'b0, brem_q} + {1'b0, nr_q};
  assign brem_carry = (brem_sum >= {1'b0, m_eff});
  assign brem_nxt   = brem_carry ? COL_W'(brem_sum - {1'b0, m_eff}) : COL_W'(brem_sum);
  assign bound_nxt  = bound_q + nq_q + FRAME_W'(brem_carry);

  assign sample_ext = {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
  assign sum_s      = $signed(ram_rdata);
  assign peak_f     = peak_q[fetch_ch_q[CHI_W-1:0]];
  assign sum_abs    = sum_s[SUM_W-1] ? (SUM_W'(0) - ram_rdata) : ram_rdata;
  assign peak_pos   = ~peak_f[SUM_W-1] && (peak_f != '0);
  // |sum| >= peak means the ratio is at least one: saturate without dividing
  assign sat        = (sum_abs >= $unsigned(peak_f));
  assign quo_level  = {1'b0, div_quo[FRAC_W-1:0]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_load) begin
            if (load_start) begin
              state_d = ST_NDIV;
            end else if (ch_q == '0) begin
              state_d = ST_ADVANCE;
            end else begin
              state_d = ST_LRD;
            end
          end else if (load_done_q) begin
            state_d = ST_FRD;
          end
        end
      end
      ST_NDIV: begin
        if (div_done) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (sweep_last) state_d = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        if (!adv_step) state_d = ST_LRD;
      end
      ST_LRD:       state_d = ST_LWR;
      ST_LWR:       state_d = (ch_last && frame_last) ? ST_PEAK : ST_IDLE;
      ST_PEAK: begin
        if (sweep_last) state_d = ST_PEAK_TAIL;
      end
      ST_PEAK_TAIL: state_d = ST_IDLE;
      ST_FRD:       state_d = ST_FCHK;
      ST_FCHK:      state_d = (peak_pos && !sat) ? ST_FDIV : ST_FOUT;
      ST_FDIV: begin
        if (div_done) state_d = ST_FOUT;
      end
      ST_FOUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cfg_ready_o = (state_q == ST_IDLE);
    in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;

    ram_we    = (state_q == ST_CLEAR) || (state_q == ST_LWR);
    ram_waddr = (state_q == ST_CLEAR) ? addr_of(sw_col_q, sw_ch_q) : addr_of(col_q, ch_q);
    ram_wdata = (state_q == ST_CLEAR) ? '0 : SUM_W'(sum_s + sample_ext);

    priority case (state_q)
      ST_FRD:  ram_raddr = addr_of(fetch_col_q, fetch_ch_q);
      ST_PEAK: ram_raddr = addr_of(sw_col_q, sw_ch_q);
      default: ram_raddr = addr_of(col_q, ch_q);
    endcase

    div_start = ((state_q == ST_IDLE) && in_acc && is_load && load_start) ||
                ((state_q == ST_FCHK) && peak_pos && !sat);
    if (state_q == ST_FCHK) begin
      div_count    = CNT_W'(FRAC_W);
      div_rem_init = sum_abs;
      div_dividend = '0;
      div_divisor  = $unsigned(peak_f);
    end else begin
      div_count    = CNT_W'(QUO_W);
      div_rem_init = '0;
      div_dividend = QUO_W'(n_eff);
      div_divisor  = SUM_W'(m_eff);
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_cols_q   <= COLS_RESET;
      cfg_frames_q <= FRAMES_RESET;
      cfg_chans_q  <= CHANS_RESET;
      frame_q      <= '0;
      ch_q         <= '0;
      col_q        <= '0;
      bound_q      <= '0;
      brem_q       <= '0;
      sw_col_q     <= '0;
      sw_ch_q      <= '0;
      fetch_col_q  <= '0;
      fetch_ch_q   <= '0;
      load_done_q  <= 1'b0;
      cmp_valid_q  <= 1'b0;
      cmp_ch_q     <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        peak_q[i] <= PEAK_RESET;
      end
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= (state_q == ST_PEAK);
      cmp_ch_q    <= sw_ch_q[CHI_W-1:0];

      if (cmp_valid_q && (sum_s > peak_q[cmp_ch_q])) begin
        peak_q[cmp_ch_q] <= sum_s;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && is_load && load_start) begin
            load_done_q <= 1'b0;
            fetch_col_q <= '0;
            fetch_ch_q  <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              peak_q[i] <= PEAK_RESET;
            end
          end
        end
        ST_NDIV: begin
          if (div_done) begin
            col_q    <= '0;
            bound_q  <= FRAME_W'(div_quo);
            brem_q   <= COL_W'(div_rem);
            sw_col_q <= '0;
            sw_ch_q  <= '0;
          end
        end
        ST_CLEAR, ST_PEAK: begin
          if (sw_ch_q == c_eff - CH_W'(1)) begin
            sw_ch_q  <= '0;
            sw_col_q <= sw_col_q + COL_W'(1);
          end else begin
            sw_ch_q <= sw_ch_q + CH_W'(1);
          end
        end
        ST_ADVANCE: begin
          if (adv_step) begin
            col_q   <= col_q + COL_W'(1);
            bound_q <= bound_nxt;
            brem_q  <= brem_nxt;
          end
        end
        ST_LWR: begin
          if (ch_last) begin
            ch_q <= '0;
            if (frame_last) begin
              frame_q  <= '0;
              sw_col_q <= '0;
              sw_ch_q  <= '0;
            end else begin
              frame_q <= frame_q + FRAME_W'(1);
            end
          end else begin
            ch_q <= ch_q + CH_W'(1);
          end
        end
        ST_PEAK_TAIL: load_done_q <= 1'b1;
        ST_FOUT: begin
          if (out_free) begin
            if (fetch_last) begin
              fetch_col_q <= '0;
              fetch_ch_q  <= '0;
            end else if (fetch_ch_q == c_eff - CH_W'(1)) begin
              fetch_ch_q  <= '0;
              fetch_col_q <= fetch_col_q + COL_W'(1);
            end else begin
              fetch_ch_q <= fetch_ch_q + CH_W'(1);
            end
          end
        end
        default: ;
      endcase

      if (fout_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // a write to a defined register index aborts any run in progress
      if (cfg_acc) begin
        unique case (wban_reg_e'(cfg_index_i))
          REG_OUTPUT_COLUMNS: cfg_cols_q   <= COLS_W'(cfg_data_i);
          REG_INPUT_FRAMES:   cfg_frames_q <= FRAMES_W'(cfg_data_i);
          REG_CHANNEL_COUNT:  cfg_chans_q  <= CHANS_W'(cfg_data_i);
          default: ;
        endcase
        if ((wban_reg_e'(cfg_index_i) == REG_OUTPUT_COLUMNS) ||
            (wban_reg_e'(cfg_index_i) == REG_INPUT_FRAMES) ||
            (wban_reg_e'(cfg_index_i) == REG_CHANNEL_COUNT)) begin
          frame_q     <= '0;
          ch_q        <= '0;
          col_q       <= '0;
          bound_q     <= '0;
          fetch_col_q <= '0;
          fetch_ch_q  <= '0;
          load_done_q <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
    if ((state_q == ST_NDIV) && div_done) begin
      nq_q <= FRAME_W'(div_quo);
      nr_q <= COL_W'(div_rem);
    end
    if (state_q == ST_FCHK) begin
      neg_q    <= sum_s[SUM_W-1];
      res_zp_q <= ~peak_pos;
      if (!peak_pos) begin
        res_level_q <= '0;
      end else begin
        res_level_q <= sum_s[SUM_W-1] ? LEVEL_MIN : LEVEL_MAX;
      end
    end
    if ((state_q == ST_FDIV) && div_done) begin
      res_level_q <= neg_q ? $signed(LEVEL_W'(0) - quo_level) : $signed(quo_level);
    end
    if (fout_fire) begin
      level_q     <= res_level_q;
      zero_peak_q <= res_zp_q;
      last_q      <= fetch_last;
    end
  end

  wban_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wban_div #(
    .REM_W (SUM_W),
    .QUO_W (QUO_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .count_i     (div_count),
    .rem_i       (div_rem_init),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign zero_peak_o = zero_peak_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FOUT))
    else $error("result word appeared outside the output state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_q < c_eff) && (fetch_ch_q < c_eff) && (col_q < m_eff) && (fetch_col_q < m_eff))
    else $error("bin counter outside the configured range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_NDIV) || (state_q == ST_FDIV)))
    else $error("divider finished with no waiting consumer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(load_done_q) |-> $past(state_q == ST_PEAK_TAIL))
    else $error("load marked done before the peak sweep ended");
`endif

endmodule

// ===== rtl/wban_ram.sv =====
// wban_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone, no package dependency.
module wban_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/wban_div.sv =====
// wban_div: restoring divider, one quotient bit per cycle.
// Shifts dividend bits in MSB first behind a preset remainder. No dependencies.
module wban_div #(
  parameter int REM_W = 28,
  parameter int QUO_W = 15,
  parameter int CNT_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [QUO_W-1:0] dividend_i,
  input  logic [REM_W-1:0] divisor_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quotient_o,
  output logic [REM_W-1:0] remainder_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REM_W-1:0] rem_q, dvs_q;
  logic [QUO_W-1:0] quo_q;
  logic [REM_W:0]   partial, diff;
  logic             fits;

  assign partial = {rem_q, quo_q[QUO_W-1]};
  assign diff    = partial - {1'b0, dvs_q};
  assign fits    = ~diff[REM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[REM_W-1:0] : partial[REM_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for wave_bin_average_normalize: loads, fetches and register writes.
// Holds a bin/peak predictor, a directed table, random phases and a result scoreboard.
// Depends on rtl/wban_pkg.sv and rtl/wave_bin_average_normalize.sv.
module testbench;
  import wban_pkg::*;

  localparam int COL_LIMIT    = 256;
  localparam int FRAME_LIMIT  = 4096;
  localparam int CHAN_LIMIT   = 8;
  localparam int BIN_W        = 28;
  localparam int DRAIN_CYCLES = 4400;
  localparam int LONG_STALL   = 400;
  localparam int FETCH_CAP    = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [BIN_W-1:0] PEAK_FLOOR = {1'b1, {(BIN_W-1){1'b0}}};

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      zero_peak;
    logic                      last;
  } level_word_t;

  typedef struct packed {
    wban_op_e                   op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       fixed_exp;
    level_word_t                want;
  } probe_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] cols;
    logic [CFG_DATA_W-1:0] frames;
    logic [CFG_DATA_W-1:0] chans;
    int                    budget;
    logic                  rsvd;
    logic                  extreme;
    logic                  squeeze;
  } phase_t;

  typedef enum {FILL_ANY, FILL_SMALL, FILL_TOP, FILL_BOTTOM, FILL_ZERO, FILL_NONPOS} fill_e;

  // M=2, N=4, C=2: bins are frames {0,1} and {2,3}
  localparam probe_row_t PROBE_ROWS [26] = '{
    '{OP_LOAD,  16'sh7FFF, 1'b0, '0},
    '{OP_LOAD,  16'sh8000, 1'b0, '0},
    '{OP_LOAD,  16'sh7FFF, 1'b0, '0},
    '{OP_LOAD,  16'sh8000, 1'b0, '0},
    '{OP_LOAD,  16'sd1,    1'b0, '0},
    '{OP_LOAD,  16'sd0,    1'b0, '0},
    '{OP_LOAD,  16'sd0,    1'b0, '0},
    '{OP_LOAD,  16'sd0,    1'b0, '0},
    '{OP_FETCH, 16'sd0,    1'b1, '{LEVEL_MAX, 1'b0, 1'b0}},
    '{OP_FETCH, 16'sd0,    1'b1, '{16'sd0,    1'b1, 1'b0}},
    '{OP_FETCH, 16'sd0,    1'b0, '0},
    '{OP_FETCH, 16'sd0,    1'b1, '{16'sd0,    1'b1, 1'b1}},
    '{OP_FETCH, 16'sd0,    1'b1, '{LEVEL_MAX, 1'b0, 1'b0}},
    '{OP_LOAD,  16'sd100,  1'b0, '0},
    '{OP_FETCH, 16'sd0,    1'b0, '0},
    '{OP_LOAD,  16'sd7,    1'b0, '0},
    '{OP_LOAD,  16'sd200,  1'b0, '0},
    '{OP_LOAD,  16'sd7,    1'b0, '0},
    '{OP_LOAD,  16'sd50,   1'b0, '0},
    '{OP_LOAD,  16'sd7,    1'b0, '0},
    '{OP_LOAD,  -16'sd350, 1'b0, '0},
    '{OP_LOAD,  16'sd7,    1'b0, '0},
    '{OP_FETCH, 16'sd0,    1'b1, '{LEVEL_MAX, 1'b0, 1'b0}},
    '{OP_FETCH, 16'sd0,    1'b1, '{LEVEL_MAX, 1'b0, 1'b0}},
    '{OP_FETCH, 16'sd0,    1'b1, '{LEVEL_MIN, 1'b0, 1'b0}},
    '{OP_FETCH, 16'sd0,    1'b1, '{LEVEL_MAX, 1'b0, 1'b1}}
  };

  // raw register values; out-of-range ones exercise clamping
  localparam phase_t PHASES [11] = '{
    '{13'd4,      13'd8,      13'd2,      250,  1'b0, 1'b0, 1'b0},
    '{13'd1,      13'd1,      13'd1,      150,  1'b0, 1'b0, 1'b0},
    '{13'd0,      13'd0,      13'd0,      80,   1'b0, 1'b0, 1'b0},
    '{13'd3,      13'd10,     13'd3,      250,  1'b0, 1'b0, 1'b1},
    '{13'd8,      13'd5,      13'd2,      200,  1'b0, 1'b0, 1'b0},
    '{13'd5,      13'd17,     13'd4,      250,  1'b0, 1'b0, 1'b0},
    '{13'd256,    13'd300,    13'd1,      700,  1'b0, 1'b0, 1'b0},
    '{13'h1FFF,   13'd2,      13'h1FFF,   120,  1'b0, 1'b0, 1'b0},
    '{13'd1,      13'h1FFF,   13'd1,      4000, 1'b0, 1'b1, 1'b0},
    '{13'd7,      13'd13,     13'd8,      200,  1'b0, 1'b0, 1'b0},
    '{13'd0,      13'd0,      13'd0,      120,  1'b1, 1'b0, 1'b0}
  };

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic                        operation_i = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [LEVEL_W-1:0]   level_o;
  logic                        zero_peak_o;
  logic                        last_o;

  // typed-in expectation that travels with the word on the input channel
  logic        word_fixed = 1'b0;
  level_word_t word_want  = '0;

  int tx_idle_pct  = 24;
  int rx_stall_pct = 50;
  int stall_asks   = 0;
  int stall_seen   = 0;
  int stall_left   = 0;
  int err_cnt      = 0;

  level_word_t levels_due[$];

  // predictor state
  logic [COLS_W-1:0]       cols_reg;
  logic [FRAMES_W-1:0]     frames_reg;
  logic [CHANS_W-1:0]      chans_reg;
  logic signed [BIN_W-1:0] bin_acc [COL_LIMIT*CHAN_LIMIT];
  logic signed [BIN_W-1:0] peak_acc [CHAN_LIMIT];
  int unsigned             frame_cnt, chan_cnt, col_cnt, bound_cnt, fetch_pos;
  logic                    loaded;

  wave_bin_average_normalize #(
    .MAX_COLUMNS  (COL_LIMIT),
    .MAX_FRAMES   (FRAME_LIMIT),
    .MAX_CHANNELS (CHAN_LIMIT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .level_o     (level_o),
    .zero_peak_o (zero_peak_o),
    .last_o      (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned eff_cols();
    if (cols_reg == 0) return 1;
    return (cols_reg > COL_LIMIT) ? COL_LIMIT : cols_reg;
  endfunction

  function automatic int unsigned eff_frames();
    if (frames_reg == 0) return 1;
    return (frames_reg > FRAME_LIMIT) ? FRAME_LIMIT : frames_reg;
  endfunction

  function automatic int unsigned eff_chans();
    if (chans_reg == 0) return 1;
    return (chans_reg > CHAN_LIMIT) ? CHAN_LIMIT : chans_reg;
  endfunction

  // upper frame bound of a column: floor((col+1)*N/M)
  function automatic int unsigned col_bound(int unsigned col, int unsigned n, int unsigned m);
    return ((col + 1) * n) / m;
  endfunction

  function automatic void rewind_run();
    frame_cnt = 0;
    chan_cnt  = 0;
    col_cnt   = 0;
    bound_cnt = 0;
    fetch_pos = 0;
    loaded    = 1'b0;
  endfunction

  function automatic void clear_bins();
    int i;
    for (i = 0; i < COL_LIMIT*CHAN_LIMIT; i++) bin_acc[i] = '0;
    for (i = 0; i < CHAN_LIMIT; i++) peak_acc[i] = PEAK_FLOOR;
  endfunction

  function automatic void init_predictor();
    cols_reg   = COLS_RESET;
    frames_reg = FRAMES_RESET;
    chans_reg  = CHANS_RESET;
    clear_bins();
    rewind_run();
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_OUTPUT_COLUMNS: cols_reg = data[COLS_W-1:0];
      REG_INPUT_FRAMES:   frames_reg = data[FRAMES_W-1:0];
      REG_CHANNEL_COUNT:  chans_reg = data[CHANS_W-1:0];
      default: return;
    endcase
    rewind_run();
  endfunction

  // returns 1 when the word yields a level word
  function automatic bit predict_level(input wban_op_e op, input logic signed [SAMPLE_W-1:0] smp,
                                       output level_word_t res);
    int unsigned m, n, c, total, i, j, pos;
    longint      scaled;
    m   = eff_cols();
    n   = eff_frames();
    c   = eff_chans();
    res = '0;
    if (op == OP_LOAD) begin
      if (frame_cnt == 0 && chan_cnt == 0) begin
        clear_bins();
        col_cnt   = 0;
        bound_cnt = col_bound(0, n, m);
        fetch_pos = 0;
        loaded    = 1'b0;
      end
      if (chan_cnt == 0) begin
        while (frame_cnt >= bound_cnt && col_cnt + 1 < m) begin
          col_cnt++;
          bound_cnt = col_bound(col_cnt, n, m);
        end
      end
      bin_acc[col_cnt*c + chan_cnt] = bin_acc[col_cnt*c + chan_cnt] + smp;
      chan_cnt++;
      if (chan_cnt >= c) begin
        chan_cnt = 0;
        frame_cnt++;
        if (frame_cnt >= n) begin
          frame_cnt = 0;
          for (i = 0; i < m; i++)
            for (j = 0; j < c; j++)
              if (bin_acc[i*c + j] > peak_acc[j]) peak_acc[j] = bin_acc[i*c + j];
          loaded = 1'b1;
        end
      end
      return 1'b0;
    end
    if (!loaded) return 1'b0;
    total = m * c;
    if (fetch_pos >= total) fetch_pos = 0;
    pos = fetch_pos;
    if (peak_acc[pos % c] <= 0) begin
      res.zero_peak = 1'b1;
    end else begin
      scaled = (longint'(bin_acc[pos]) * 32768) / longint'(peak_acc[pos % c]);
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      res.level = scaled[LEVEL_W-1:0];
    end
    res.last  = (pos + 1 == total);
    fetch_pos = res.last ? 0 : pos + 1;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    level_word_t due, oldest;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        if (predict_level(wban_op_e'(operation_i), sample_i, due))
          levels_due.push_back(word_fixed ? word_want : due);
      end
      if (out_valid_o && out_ready_i) begin
        if (levels_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word level=%0d zero_peak=%0b last=%0b",
                   $time, level_o, zero_peak_o, last_o);
        end else begin
          oldest = levels_due.pop_front();
          if (level_o !== oldest.level) begin
            err_cnt++;
            $display("%0t: level expected %0d actual %0d", $time, oldest.level, level_o);
          end
          if (zero_peak_o !== oldest.zero_peak) begin
            err_cnt++;
            $display("%0t: zero_peak expected %0b actual %0b", $time, oldest.zero_peak,
                     zero_peak_o);
          end
          if (last_o !== oldest.last) begin
            err_cnt++;
            $display("%0t: last expected %0b actual %0b", $time, oldest.last, last_o);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_asks != stall_seen) begin
      stall_seen  <= stall_asks;
      stall_left  <= LONG_STALL;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic push_word(input wban_op_e op, input logic signed [SAMPLE_W-1:0] smp,
                           input logic fixed, input level_word_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    sample_i    <= smp;
    word_fixed  <= fixed;
    word_want   <= want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait out every expected word, then the longest clear/peak sweep
  task automatic settle();
    in_valid_i <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic fill_e pick_fill();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return FILL_ANY;
    if (r < 60) return FILL_SMALL;
    if (r < 70) return FILL_TOP;
    if (r < 80) return FILL_BOTTOM;
    if (r < 90) return FILL_ZERO;
    return FILL_NONPOS;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(fill_e f);
    int v;
    case (f)
      FILL_SMALL:  v = int'($urandom_range(0, 200)) - 100;
      FILL_TOP:    v = 32767;
      FILL_BOTTOM: v = -32768;
      FILL_ZERO:   v = 0;
      FILL_NONPOS: v = -int'($urandom_range(0, 1000));
      default:     v = int'($urandom_range(0, 65535));
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // mostly complete loads followed by fetch bursts; some cut-off loads and noise
  task automatic play_phase(input int budget, input bit extreme, input bit squeeze);
    int    sent, m, n, c, words, cnt, k, j;
    fill_e fills [CHAN_LIMIT];
    sent = 0;
    while (sent < budget) begin
      m     = eff_cols();
      n     = eff_frames();
      c     = eff_chans();
      words = n * c;
      k     = extreme ? 0 : $urandom_range(0, 99);
      if (k < 70) begin
        for (j = 0; j < CHAN_LIMIT; j++)
          fills[j] = extreme ? ($urandom_range(0, 1) ? FILL_TOP : FILL_BOTTOM) : pick_fill();
        for (j = 0; j < words; j++)
          push_word(OP_LOAD, draw_sample(fills[j % c]), 1'b0, '0);
        cnt = $urandom_range(1, (m*c + 3 < FETCH_CAP) ? m*c + 3 : FETCH_CAP);
        if (squeeze) begin
          // hold the receiver off while fetches keep coming
          cnt        = 30;
          stall_asks <= stall_asks + 1;
          squeeze    = 1'b0;
        end
        for (j = 0; j < cnt; j++) push_word(OP_FETCH, 16'($urandom), 1'b0, '0);
        sent += words + cnt;
      end else if (k < 85 && words > 1) begin
        cnt = $urandom_range(1, (words - 1 < 200) ? words - 1 : 200);
        for (j = 0; j < cnt; j++) push_word(OP_LOAD, draw_sample(FILL_ANY), 1'b0, '0);
        k = $urandom_range(1, 3);
        for (j = 0; j < k; j++) push_word(OP_FETCH, 16'($urandom), 1'b0, '0);
        sent += cnt + k;
      end else begin
        cnt = $urandom_range(1, 8);
        for (j = 0; j < cnt; j++)
          push_word(wban_op_e'($urandom_range(0, 1)), 16'($urandom), 1'b0, '0);
        sent += cnt;
      end
    end
  endtask

  initial begin
    int p;
    init_predictor();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_reg(REG_OUTPUT_COLUMNS, 13'd2);
    write_reg(REG_INPUT_FRAMES, 13'd4);
    write_reg(REG_CHANNEL_COUNT, 13'd2);
    for (p = 0; p < 26; p++)
      push_word(PROBE_ROWS[p].op, PROBE_ROWS[p].sample, PROBE_ROWS[p].fixed_exp,
                PROBE_ROWS[p].want);
    settle();
    for (p = 0; p < 11; p++) begin
      if (p == 4) begin
        tx_idle_pct  = 50;
        rx_stall_pct = 24;
      end else if (p == 8) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      if (PHASES[p].rsvd) begin
        // unused index: stored nowhere, the run in progress carries on
        write_reg(REG_UNUSED, 13'($urandom));
      end else begin
        write_reg(REG_OUTPUT_COLUMNS, PHASES[p].cols);
        write_reg(REG_INPUT_FRAMES, PHASES[p].frames);
        write_reg(REG_CHANNEL_COUNT, PHASES[p].chans);
      end
      play_phase(PHASES[p].budget, PHASES[p].extreme, PHASES[p].squeeze);
      settle();
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== wave_bin_average_normalize.f =====
rtl/wban_pkg.sv
rtl/wban_ram.sv
rtl/wban_div.sv
rtl/wave_bin_average_normalize.sv
tb/testbench.sv
